[rtl/abh_pkg.sv]
// Package: constants, types and round helpers for the ARX block hash.
package abh_pkg;
    typedef logic [3:0][63:0]  t_w4;
    typedef logic [15:0][63:0] t_w16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_BLK,
        S_FIN,
        S_OUT
    } t_state;

    localparam int ROUND_COUNT_DEF = 64;
    localparam logic [9:0] TAIL_LIMIT_BITS = 10'd768;

    localparam t_w4 IV_TOP = '{
        64'ha1513c69681ad6d4, 64'h70b7ed67fc9b5c42,
        64'h5815a7be0543c11c, 64'h0cc4a61194f81760};
    localparam t_w4 IV_BOT = '{
        64'hca320b75e2b634f9, 64'hb467369e08efd70e,
        64'h720dcdfd9dba5b44, 64'h44f9363580e83d02};

    function automatic logic [63:0] round_const(input logic [5:0] r);
        logic [63:0] c;
        unique case (r)
            6'd0:  c = 64'h243f6a8885a308d3;  6'd1:  c = 64'h13198a2e03707344;
            6'd2:  c = 64'ha4093822299f31d0;  6'd3:  c = 64'h082efa98ec4e6c89;
            6'd4:  c = 64'h452821e638d01377;  6'd5:  c = 64'hbe5466cf34e90c6c;
            6'd6:  c = 64'hc0ac29b7c97c50dd;  6'd7:  c = 64'h3f84d5b5b5470917;
            6'd8:  c = 64'h9216d5d98979fb1b;  6'd9:  c = 64'hd1310ba698dfb5ac;
            6'd10: c = 64'h2ffd72dbd01adfb7;  6'd11: c = 64'hb8e1afed6a267e96;
            6'd12: c = 64'hba7c9045f12c7f99;  6'd13: c = 64'h24a19947b3916cf7;
            6'd14: c = 64'h0801f2e2858efc16;  6'd15: c = 64'h636920d871574e69;
            6'd16: c = 64'ha458fea3f4933d7e;  6'd17: c = 64'h0d95748f728eb658;
            6'd18: c = 64'h718bcd5882154aee;  6'd19: c = 64'h7b54a41dc25a59b5;
            6'd20: c = 64'h9c30d5392af26013;  6'd21: c = 64'hc5d1b023286085f0;
            6'd22: c = 64'hca417918b8db38ef;  6'd23: c = 64'h8e79dcb0603a180e;
            6'd24: c = 64'h6c9e0e8bb01e8a3e;  6'd25: c = 64'hd71577c1bd314b27;
            6'd26: c = 64'h78af2fda55605c60;  6'd27: c = 64'he65525f3aa55ab94;
            6'd28: c = 64'h5748986263e81440;  6'd29: c = 64'h55ca396a2aab10b6;
            6'd30: c = 64'hb4cc5c341141e8ce;  6'd31: c = 64'ha15486af7c72e993;
            6'd32: c = 64'hb3ee1411636fbc2a;  6'd33: c = 64'h2ba9c55d741831f6;
            6'd34: c = 64'hce5c3e169b87931e;  6'd35: c = 64'hafd6ba336c24cf5c;
            6'd36: c = 64'h7a32538128958677;  6'd37: c = 64'h3b8f48986b4bb9af;
            6'd38: c = 64'hc4bfe81b66282193;  6'd39: c = 64'h61d809ccfb21a991;
            6'd40: c = 64'h487cac605dec8032;  6'd41: c = 64'hef845d5de98575b1;
            6'd42: c = 64'hdc262302eb651b88;  6'd43: c = 64'h23893e81d396acc5;
            6'd44: c = 64'h0f6d6ff383f44239;  6'd45: c = 64'h2e0b4482a4842004;
            6'd46: c = 64'h69c8f04a9e1f9b5e;  6'd47: c = 64'h21c66842f6e96c9a;
            6'd48: c = 64'h670c9c61abd388f0;  6'd49: c = 64'h6a51a0d2d8542f68;
            6'd50: c = 64'h960fa728ab5133a3;  6'd51: c = 64'h6eef0b6c137a3be4;
            6'd52: c = 64'hba3bf0507efb2a98;  6'd53: c = 64'ha1f1651d39af0176;
            6'd54: c = 64'h66ca593e82430e88;  6'd55: c = 64'h8cee8619456f9fb4;
            6'd56: c = 64'h7d84a5c33b8b5ebe;  6'd57: c = 64'he06f75d885c12073;
            6'd58: c = 64'h401a449f56c16aa6;  6'd59: c = 64'h4ed3aa62363f7706;
            6'd60: c = 64'h1bfedf72429b023d;  6'd61: c = 64'h37d0d724d00a1248;
            6'd62: c = 64'hdb0fead349f1c09b;  default: c = 64'h075372c980991b7b;
        endcase
        return c;
    endfunction

    function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
        return (v << n) | (v >> (64 - n));
    endfunction

    // one round of one lane
    function automatic t_w4 lane_round(input t_w4 x, input logic [63:0] rk0,
                                       input logic [63:0] rk1, input logic [63:0] rk2,
                                       input logic [63:0] rk3, input logic [63:0] rc);
        logic [63:0] xt;
        t_w4 y;
        xt   = x[2] ^ x[3];
        y[0] = x[2];
        y[1] = x[3];
        y[2] = rol64(x[0] ^ rk0 ^ rc, 7) + rol64(xt ^ rk3, 20);
        y[3] = rol64(x[1] ^ rk1, 31) + rol64(xt ^ rk2, 56);
        return y;
    endfunction

    function automatic t_w16 msg_sched(input t_w16 m);
        logic [63:0] a23;
        logic [63:0] a1011;
        t_w16 n;
        a23   = m[2] ^ m[3];
        a1011 = m[10] ^ m[11];
        n[0]  = m[6];
        n[1]  = m[7];
        n[2]  = rol64(m[8], 29) + rol64(a1011, 6);
        n[3]  = rol64(m[9], 63) + rol64(a1011, 12);
        n[4]  = m[10];
        n[5]  = m[11];
        n[6]  = m[12];
        n[7]  = m[13];
        n[8]  = m[14];
        n[9]  = m[15];
        n[10] = rol64(m[0], 14) + rol64(a23, 19);
        n[11] = rol64(m[1], 43) + rol64(a23, 28);
        n[12] = m[2];
        n[13] = m[3];
        n[14] = m[4];
        n[15] = m[5];
        return n;
    endfunction
endpackage

[rtl/abh_if.sv]
// Request channels: message words in, digest words out.
interface abh_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [6:0]  word_bits;
    logic        last;
    modport source (output valid, msg_word, word_bits, last, input ready);
    modport sink (input valid, msg_word, word_bits, last, output ready);
endinterface

interface abh_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink (input valid, digest_word, digest_last, output ready);
endinterface

[rtl/arx_block_hash_512.sv]
// Top level: streaming 512-bit ARX block hash with a one-round-per-cycle cipher.
// Usage:
//   i_msg carries one message word per request (msg_word, word_bits, last).
//   o_dig returns eight digest words after a request marked last, the
//   eighth flagged by digest_last.
// Sequence:
//   A non-last word that does not fill the block is only buffered.
//   The sixteenth word triggers a compression: a decision state, ROUND_COUNT
//   rounds that run both cipher lanes on a shared round key, then a decision.
//   A last word adds a decision, an optional tail compression (ROUND_COUNT
//   rounds), the final encryption (ROUND_COUNT rounds) and the output of
//   the eight digest words, each held until o_dig.ready is high.
// Reset:
//   i_rst_n (synchronous, low) loads the chaining values and clears the
//   word and bit counts; the block buffer is not cleared.
// Stalls:
//   A digest word holds while o_dig.ready is low; no message word is taken
//   until the last digest word is delivered, after which state returns to
//   its reset values for the next message.
module arx_block_hash_512
    import abh_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    abh_msg_if.sink   i_msg,
    abh_dig_if.source o_dig
);
    localparam logic [5:0] LAST_RND = 6'(ROUND_COUNT - 1);

    t_state      r_state, n_state;
    t_w4         r_top, r_bot;
    t_w16        r_buf;
    logic [4:0]  r_held;
    logic [63:0] r_total;
    logic        r_fin, r_need, r_tailc;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    t_w16        r_m;
    t_w4         r_k, r_xa, r_xb;
    logic [63:0] r_c0, r_c1;

    logic        acc, out_acc, do_blk, rnd_done;
    logic [6:0]  wb;
    logic [63:0] wmask;
    logic [63:0] rk0, rk1, rk2, rk3, rc;
    t_w16        mk_blk, mk_fin;
    t_w4         bk_fin;
    t_w4         ya_nxt, yb_nxt;

    assign acc     = i_msg.valid && i_msg.ready;
    assign out_acc = o_dig.valid && o_dig.ready;
    assign wb      = (i_msg.word_bits > 7'd64) ? 7'd64 : i_msg.word_bits;
    assign wmask   = i_msg.msg_word & ~(~64'd0 >> wb);
    assign do_blk  = r_need ||
                     (r_fin && !r_tailc && (r_total[9:0] > TAIL_LIMIT_BITS));
    assign rnd_done = (r_rnd == LAST_RND);

    assign rk0 = r_m[0] ^ r_k[0] ^ r_c0;
    assign rk1 = r_m[1] ^ r_k[1] ^ r_c1;
    assign rk2 = r_m[8] ^ r_k[2];
    assign rk3 = r_m[9] ^ r_k[3];
    assign rc  = round_const(r_rnd);

    assign ya_nxt = lane_round(r_xa, rk0, rk1, rk2, rk3, rc);
    assign yb_nxt = lane_round(r_xb, rk0, rk1, rk2, rk3, rc);

    function automatic logic n_need_w();
        return (wb != 7'd0) && (r_held + 5'd1 >= 5'd16) &&
               (!i_msg.last || wb == 7'd64);
    endfunction

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            mk_blk[i] = (5'(i) < r_held) ? r_buf[i] : 64'd0;
        end
        for (int i = 0; i < 4; i++) begin
            mk_fin[i]     = r_top[i];
            mk_fin[4 + i] = r_bot[i];
            bk_fin[i]     = mk_blk[8 + i];
        end
        for (int i = 0; i < 8; i++) begin
            mk_fin[8 + i] = mk_blk[i];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_msg.last || n_need_w())) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (do_blk) begin
                    n_state = S_BLK;
                end else if (r_fin) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BLK: if (rnd_done) n_state = S_DEC;
            S_FIN: if (rnd_done) n_state = S_OUT;
            S_OUT: if (out_acc && r_idx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_msg.ready       = (r_state == S_IDLE);
        o_dig.valid       = (r_state == S_OUT);
        o_dig.digest_word = r_idx[2] ? r_xb[r_idx[1:0]] : r_xa[r_idx[1:0]];
        o_dig.digest_last = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= IV_TOP;
            r_bot   <= IV_BOT;
            r_held  <= 5'd0;
            r_total <= 64'd0;
            r_fin   <= 1'b0;
            r_need  <= 1'b0;
            r_tailc <= 1'b0;
            r_rnd   <= 6'd0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_fin   <= i_msg.last;
                        r_need  <= n_need_w();
                        r_tailc <= 1'b0;
                        if (wb != 7'd0) begin
                            r_held  <= r_held + 5'd1;
                            r_total <= r_total + (i_msg.last ? {57'd0, wb} : 64'd64);
                        end
                    end
                end
                S_DEC: begin
                    r_rnd  <= 6'd0;
                    r_need <= 1'b0;
                    if (do_blk && r_fin) r_tailc <= 1'b1;
                end
                S_BLK: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (rnd_done) begin
                        for (int i = 0; i < 4; i++) begin
                            r_top[i] <= ya_nxt[i] ^ r_top[i];
                            r_bot[i] <= yb_nxt[i] ^ r_top[i]
                                        ^ ((i == 3) ? 64'd1 : 64'd0);
                        end
                        r_held <= 5'd0;
                    end
                end
                S_FIN: begin
                    r_rnd <= r_rnd + 6'd1;
                    r_idx <= 3'd0;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_top   <= IV_TOP;
                            r_bot   <= IV_BOT;
                            r_held  <= 5'd0;
                            r_total <= 64'd0;
                            r_fin   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: buffer, key schedule and lanes
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && acc && wb != 7'd0 && r_held < 5'd16) begin
            r_buf[r_held[3:0]] <= wmask;
        end
        if (r_state == S_DEC) begin
            r_c0 <= 64'd0;
            r_c1 <= r_total;
            if (do_blk) begin
                r_m  <= mk_blk;
                r_k  <= r_bot;
                r_xa <= r_top;
                r_xb <= r_top ^ {64'd1, 192'd0};
            end else begin
                r_m  <= mk_fin;
                r_k  <= bk_fin;
                r_xa <= {64'd2, 192'd0};
                r_xb <= {64'd3, 192'd0};
            end
        end else if (r_state == S_BLK || r_state == S_FIN) begin
            r_m  <= msg_sched(r_m);
            r_k  <= {rol64(r_k[0], 27) ^ r_k[1], r_k[3], r_k[2], r_k[1]};
            r_c0 <= r_c1;
            r_c1 <= rol64(r_c0, 2);
            r_xa <= ya_nxt;
            r_xb <= yb_nxt;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_dig.valid && i_msg.ready)) else $error("input taken during digest");
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 5'd16) else $error("word count overflow");
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_dig.digest_last) |=> (r_held == 5'd0 && r_total == 64'd0))
        else $error("state not cleared after digest");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLK && rnd_done) |=> r_state == S_DEC)
        else $error("compression did not return");
endmodule
